FILE: src/fpmt_pkg.sv
// Package: shared types and a constant for the truncated fp32 multiplier.
package fpmt_pkg;

  localparam int unsigned ExpBias = 127;

  // stage 1 -> stage 2: partial products and exponent info
  typedef struct packed {
    logic        sign;
    logic        zero_in;
    logic        exp_zero;
    logic [8:0]  exp_sum;     // ea + eb
    logic [25:0] p_hh;        // 13x13
    logic [23:0] p_hl;        // 13x11
    logic [23:0] p_lh;        // 11x13
  } s1_t;

  // stage 2 -> stage 3: summed mantissa and base exponent
  typedef struct packed {
    logic        sign;
    logic        zero_in;
    logic signed [9:0] exp_base;
    logic [26:0] msum;
  } s2_t;

endpackage

FILE: src/fpmt_mult.sv
// Stage 1: operand split, partial products, sign, zero flags and exponent sum.
module fpmt_mult (
  input  logic             [31:0] operand_a,
  input  logic             [31:0] operand_b,
  output fpmt_pkg::s1_t           s1
);
  logic [12:0] a_hi, b_hi;
  logic [10:0] a_lo, b_lo;
  logic [7:0]  ea, eb;

  always_comb begin
    a_hi = {1'b1, operand_a[22:11]};
    b_hi = {1'b1, operand_b[22:11]};
    a_lo = operand_a[10:0];
    b_lo = operand_b[10:0];
    ea = operand_a[30:23];
    eb = operand_b[30:23];
    s1.sign = operand_a[31] ^ operand_b[31];
    s1.zero_in = (operand_a[30:0] == 31'd0) || (operand_b[30:0] == 31'd0);
    s1.exp_zero = (ea == 8'd0) || (eb == 8'd0);
    s1.exp_sum = {1'b0, ea} + {1'b0, eb};
    s1.p_hh = a_hi * b_hi;
    s1.p_hl = a_hi * {2'b00, b_lo};
    s1.p_lh = {2'b00, a_lo} * b_hi;
  end
endmodule

FILE: src/fpmt_sum.sv
// Stage 2: partial product sum and base exponent.
module fpmt_sum (
  input  fpmt_pkg::s1_t s1,
  output fpmt_pkg::s2_t s2
);
  always_comb begin
    s2.sign = s1.sign;
    s2.zero_in = s1.zero_in;
    s2.exp_base = s1.exp_zero ? 10'sd0 :
                  $signed({1'b0, s1.exp_sum}) - 10'(fpmt_pkg::ExpBias);
    s2.msum = {1'b0, s1.p_hh} + {14'd0, s1.p_hl[23:11]} +
              {14'd0, s1.p_lh[23:11]} + 27'd2;
  end
endmodule

FILE: src/fpmt_norm.sv
// Stage 3: normalize, range check, pack.
module fpmt_norm (
  input  fpmt_pkg::s2_t        s2,
  output logic          [31:0] product
);
  logic signed [9:0] e;
  logic [22:0] frac;
  always_comb begin
    if (s2.msum[25]) begin
      e = s2.exp_base + 10'sd1;
      frac = s2.msum[24:2];
    end else begin
      e = s2.exp_base;
      frac = s2.msum[23:1];
    end
    if (s2.zero_in || e < 10'sd0 || e > 10'sd255) begin
      product = {s2.sign, 31'd0};
    end else begin
      product = {s2.sign, e[7:0], frac};
    end
  end
endmodule

FILE: src/fp32_multiply_truncated.sv
// Top level: three-stage truncated fp32 multiplier pipeline.
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | operand_a, operand_b
//  out     | out_valid | out_stall | product
// One transaction per cycle while out_stall is low; registered after multiply, sum and normalize.
// Reset clears the stage valid bits only.
// A stage advances when it is empty or the stage after it advances; out_stall
// freezes the full pipe, bubbles are squeezed out.
module fp32_multiply_truncated (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] product
);
  fpmt_pkg::s1_t s1_c, s1;
  fpmt_pkg::s2_t s2_c, s2;
  logic [31:0] prod_c;
  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  fpmt_mult u_mult (.operand_a(operand_a), .operand_b(operand_b), .s1(s1_c));
  fpmt_sum  u_sum  (.s1(s1), .s2(s2_c));
  fpmt_norm u_norm (.s2(s2), .product(prod_c));

  assign adv3 = !v3 || !out_stall;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_stall = !adv1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
    if (adv1 && in_valid) s1 <= s1_c;
    if (adv2 && v1) s2 <= s2_c;
    if (adv3 && v2) product <= prod_c;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(product))
    else $error("result changed under stall");
  a_nostall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled with free output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    v2 && !v3 |=> v3)
    else $error("stage 2 item lost");
endmodule
